@@ rtl/bpfl_pkg.sv @@
// Shared types, constants and helpers for the binding pool free list.
package bpfl_pkg;

	// Pool geometry.
	localparam int SLOTS = 128;
	localparam int LINK_W = 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam logic [LINK_W-1:0] NULL_LINK = 8'hFF;

	// Item field widths.
	localparam int CODE_W = 8;
	localparam int TRIG_W = 2;
	localparam int HID_W = 16;
	localparam int KEY_W = 1 + CODE_W + TRIG_W + HID_W;
	localparam int STATUS_W = 2;
	localparam int OUT_SLOT_W = 7;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_BIND_WR,
		ST_BIND_LINK,
		ST_WALK,
		ST_UNL_B,
		ST_UNL_C,
		ST_RESP
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_TAKE,
		OP_BIND_RD,
		OP_BIND_WR,
		OP_BIND_LINK,
		OP_FULL,
		OP_WALK_START,
		OP_WALK_STEP,
		OP_MATCH,
		OP_UNL_B,
		OP_UNL_C,
		OP_NOT_FOUND
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic kind_unbind;
		logic free_ok;
		logic used_ok;
		logic match;
		logic next_ok;
		logic steps_last;
		logic out_free;
	} dp_stat_t;

	// A link names a slot only if it is in range and not the null marker.
	function automatic logic is_slot(input logic [LINK_W-1:0] v);
		return (v < LINK_W'(SLOTS)) && (v != NULL_LINK);
	endfunction

endpackage

@@ rtl/binding_pool_free_list.sv @@
// Top level of the binding pool allocator: free list plus doubly linked in-use list.
// Bind: START, BIND_WR, BIND_LINK, then RESP (straight to RESP when full) loads the result once
// the output is free. Unbind: the walk examines in-use entries one per cycle through the link
// memory read port (up to SLOTS), then UNL_B, UNL_C and RESP; not found goes straight to RESP.
// After reset a clearing pass over SLOTS (128) slots builds the free chain; no item is taken then.
// Reset empties the in-use list, puts every slot on the free list and drops any pending result.
module binding_pool_free_list (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input items.
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// tdata: source_is_button[0], input_code[8:1], trigger_state[10:9], handler_id[26:11]
	input  logic [bpfl_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// tuser: kind[0]
	input  logic                              s_axis_tuser,
	// Result items.
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// tdata: status[1:0], slot_index[8:2]
	output logic [bpfl_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import bpfl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	bpfl_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.stat          (stat),
		.cmd           (cmd)
	);

	// Lists, memories and result register.
	bpfl_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

@@ rtl/bpfl_ram.sv @@
// Generic single write port RAM with one registered read port.
module bpfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/bpfl_ctrl.sv @@
// Controller state machine that sequences bind, unbind walk and result hand-off.
module bpfl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  bpfl_pkg::dp_stat_t stat,
	output bpfl_pkg::dp_cmd_t  cmd
);
	import bpfl_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd.op = OP_NONE;
		cmd.out_load = 1'b0;
		s_axis_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					cmd.op = OP_TAKE;
					state_d = ST_START;
				end
			end
			ST_START: begin
				if (!stat.kind_unbind) begin
					if (stat.free_ok) begin
						cmd.op = OP_BIND_RD;
						state_d = ST_BIND_WR;
					end else begin
						cmd.op = OP_FULL;
						state_d = ST_RESP;
					end
				end else if (stat.used_ok) begin
					cmd.op = OP_WALK_START;
					state_d = ST_WALK;
				end else begin
					cmd.op = OP_NOT_FOUND;
					state_d = ST_RESP;
				end
			end
			ST_BIND_WR: begin
				cmd.op = OP_BIND_WR;
				state_d = ST_BIND_LINK;
			end
			ST_BIND_LINK: begin
				cmd.op = OP_BIND_LINK;
				state_d = ST_RESP;
			end
			ST_WALK: begin
				priority if (stat.match) begin
					cmd.op = OP_MATCH;
					state_d = ST_UNL_B;
				end else if (!stat.next_ok || stat.steps_last) begin
					cmd.op = OP_NOT_FOUND;
					state_d = ST_RESP;
				end else begin
					cmd.op = OP_WALK_STEP;
				end
			end
			ST_UNL_B: begin
				cmd.op = OP_UNL_B;
				state_d = ST_UNL_C;
			end
			ST_UNL_C: begin
				cmd.op = OP_UNL_C;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A walk that runs out of entries without a match must end in a not-found result.
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && !stat.match && !stat.next_ok) |=> state_q == ST_RESP)
		else $error("walk past the list end did not finish");

endmodule

@@ rtl/bpfl_dp.sv @@
// Datapath: list heads, link and content memories, walk registers, result register.
module bpfl_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bpfl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [bpfl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input  bpfl_pkg::dp_cmd_t                   cmd,
	output bpfl_pkg::dp_stat_t                  stat
);
	import bpfl_pkg::*;

	localparam int OUT_PAD = OUT_TDATA_W - STATUS_W - OUT_SLOT_W;

	// Control registers.
	logic [LINK_W-1:0] free_head_q;
	logic [LINK_W-1:0] used_head_q;
	logic [SLOT_W-1:0] clr_q;
	logic [SLOT_W-1:0] steps_q;
	logic              m_valid_q;

	// Payload registers.
	logic                  kind_q;
	logic [KEY_W-1:0]      key_q;
	logic [LINK_W-1:0]     cur_q;
	logic [LINK_W-1:0]     p_q;
	logic [LINK_W-1:0]     n_q;
	status_t               res_status_q;
	logic [OUT_SLOT_W-1:0] res_slot_q;
	logic [OUT_TDATA_W-1:0] m_data_q;

	// Memory ports.
	logic              nl_we;
	logic [SLOT_W-1:0] nl_waddr;
	logic [LINK_W-1:0] nl_wdata;
	logic [LINK_W-1:0] nl_rdata;
	logic              pl_we;
	logic [SLOT_W-1:0] pl_waddr;
	logic [LINK_W-1:0] pl_wdata;
	logic [LINK_W-1:0] pl_rdata;
	logic              ec_we;
	logic [KEY_W-1:0]  ec_rdata;
	logic [SLOT_W-1:0] rd_addr;

	logic [KEY_W-1:0] in_key;

	// Stored binding is {source_is_button, input_code, trigger_state, handler_id}.
	assign in_key = {s_axis_tdata[0], s_axis_tdata[8:1], s_axis_tdata[10:9],
		s_axis_tdata[26:11]};

	bpfl_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_next_ram (
		.clk   (clk),
		.we    (nl_we),
		.waddr (nl_waddr),
		.wdata (nl_wdata),
		.raddr (rd_addr),
		.rdata (nl_rdata)
	);

	bpfl_ram #(.WIDTH(LINK_W), .DEPTH(SLOTS)) u_prev_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_waddr),
		.wdata (pl_wdata),
		.raddr (rd_addr),
		.rdata (pl_rdata)
	);

	bpfl_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_entry_ram (
		.clk   (clk),
		.we    (ec_we),
		.waddr (cur_q[SLOT_W-1:0]),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (ec_rdata)
	);

	// Memory address and write selection per command.
	always_comb begin
		nl_we = 1'b0;
		nl_waddr = cur_q[SLOT_W-1:0];
		nl_wdata = NULL_LINK;
		pl_we = 1'b0;
		pl_waddr = cur_q[SLOT_W-1:0];
		pl_wdata = NULL_LINK;
		ec_we = 1'b0;
		rd_addr = cur_q[SLOT_W-1:0];
		unique case (cmd.op)
			OP_CLEAR: begin
				nl_we = 1'b1;
				nl_waddr = clr_q;
				nl_wdata = (clr_q == SLOT_W'(SLOTS - 1)) ? NULL_LINK
					: LINK_W'(clr_q) + LINK_W'(1);
				pl_we = 1'b1;
				pl_waddr = clr_q;
				pl_wdata = (clr_q == '0) ? NULL_LINK : LINK_W'(clr_q) - LINK_W'(1);
			end
			OP_BIND_RD: begin
				rd_addr = free_head_q[SLOT_W-1:0];
			end
			OP_BIND_WR: begin
				nl_we = 1'b1;
				nl_wdata = used_head_q;
				pl_we = 1'b1;
				ec_we = 1'b1;
			end
			OP_BIND_LINK: begin
				pl_we = is_slot(used_head_q);
				pl_waddr = used_head_q[SLOT_W-1:0];
				pl_wdata = cur_q;
			end
			OP_WALK_START: begin
				rd_addr = used_head_q[SLOT_W-1:0];
			end
			OP_WALK_STEP: begin
				rd_addr = nl_rdata[SLOT_W-1:0];
			end
			OP_MATCH: begin
				// Predecessor skips the matched slot; the slot loses its back link.
				nl_we = is_slot(pl_rdata);
				nl_waddr = pl_rdata[SLOT_W-1:0];
				nl_wdata = nl_rdata;
				pl_we = 1'b1;
			end
			OP_UNL_B: begin
				nl_we = 1'b1;
				nl_wdata = free_head_q;
				pl_we = is_slot(n_q);
				pl_waddr = n_q[SLOT_W-1:0];
				pl_wdata = p_q;
			end
			OP_UNL_C: begin
				pl_we = is_slot(free_head_q);
				pl_waddr = free_head_q[SLOT_W-1:0];
				pl_wdata = cur_q;
			end
			default: begin
			end
		endcase
	end

	// List heads, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			used_head_q <= NULL_LINK;
			clr_q <= '0;
			steps_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				OP_CLEAR:      clr_q <= clr_q + SLOT_W'(1);
				OP_BIND_WR:    free_head_q <= nl_rdata;
				OP_BIND_LINK:  used_head_q <= cur_q;
				OP_WALK_START: steps_q <= '0;
				OP_WALK_STEP:  steps_q <= steps_q + SLOT_W'(1);
				OP_UNL_C: begin
					if (cur_q == used_head_q) begin
						used_head_q <= n_q;
					end
					free_head_q <= cur_q;
				end
				default: begin
				end
			endcase
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Item, walk position and result payload.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_TAKE: begin
				kind_q <= s_axis_tuser;
				key_q <= in_key;
			end
			OP_BIND_RD:    cur_q <= free_head_q;
			OP_BIND_WR: begin
				res_status_q <= STATUS_OK;
				res_slot_q <= cur_q[OUT_SLOT_W-1:0];
			end
			OP_FULL: begin
				res_status_q <= STATUS_FULL;
				res_slot_q <= '0;
			end
			OP_WALK_START: cur_q <= used_head_q;
			OP_WALK_STEP:  cur_q <= nl_rdata;
			OP_MATCH: begin
				p_q <= pl_rdata;
				n_q <= nl_rdata;
				res_status_q <= STATUS_OK;
				res_slot_q <= cur_q[OUT_SLOT_W-1:0];
			end
			OP_NOT_FOUND: begin
				res_status_q <= STATUS_NOT_FOUND;
				res_slot_q <= '0;
			end
			default: begin
			end
		endcase
		if (cmd.out_load) begin
			m_data_q <= {{OUT_PAD{1'b0}}, res_slot_q, res_status_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;

	// Status toward the controller.
	always_comb begin
		stat.clear_last = (clr_q == SLOT_W'(SLOTS - 1));
		stat.kind_unbind = kind_q;
		stat.free_ok = is_slot(free_head_q);
		stat.used_ok = is_slot(used_head_q);
		stat.match = (ec_rdata == key_q);
		stat.next_ok = is_slot(nl_rdata);
		stat.steps_last = (steps_q == SLOT_W'(SLOTS - 1));
		stat.out_free = !m_valid_q || m_axis_tready;
	end

	// A bind only ever writes into a real slot.
	a_bind_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_BIND_WR) |-> is_slot(cur_q))
		else $error("bind writes through a null link");

	// A freed slot becomes the free head.
	a_free_push: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_UNL_C) |=> free_head_q == $past(cur_q))
		else $error("freed slot not at free head");

	// A new result never overwrites one still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_valid_q || m_axis_tready))
		else $error("pending result overwritten");

endmodule
